// ----- hdl/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types and constants of the record mark deframer.
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int LEN_W      = 31;
    localparam int BYTE_W     = 8;
    localparam int HDR_CNT_W  = 2;
    localparam int HDR_SHIFT_W = 24;

    // The last header byte arrives when three have already been collected.
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = 2'd3;

    localparam logic [LEN_W-1:0] MAX_RESET = 31'd8388608;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              msg_end;
        logic              frame_error;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/rmd_front.sv -----
// ----------------------------------------------------------------------------
// rmd_front
// Header parser and body byte classifier; pushes one result per output item.
// ----------------------------------------------------------------------------
module rmd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [rmd_pkg::BYTE_W-1:0] i_data,
    input  logic [rmd_pkg::LEN_W-1:0] i_max,
    input  rmd_pkg::t_q_stat          i_q_stat,
    output logic                      o_push,
    output rmd_pkg::t_result          o_res
);
    import rmd_pkg::*;

    logic [HDR_CNT_W-1:0]   r_hdr_cnt,   n_hdr_cnt;
    logic [HDR_SHIFT_W-1:0] r_hdr_shift, n_hdr_shift;
    logic [LEN_W-1:0]       r_frag_rem,  n_frag_rem;
    logic                   r_in_body,   n_in_body;
    logic                   r_last_frag, n_last_frag;
    logic [LEN_W-1:0]       r_msg_len,   n_msg_len;
    logic                   r_err,       n_err;

    logic             accept;
    logic [31:0]      word;
    logic [LEN_W-1:0] hdr_len;
    logic             hdr_last;
    logic [LEN_W:0]   len_sum;
    logic             over;

    assign o_ready  = !i_q_stat.full;
    assign accept   = i_valid && o_ready;
    assign word     = {r_hdr_shift, i_data};
    assign hdr_len  = word[LEN_W-1:0];
    assign hdr_last = word[31];
    // The sum of two 31-bit values carries one extra bit so it cannot wrap.
    assign len_sum  = {1'b0, r_msg_len} + {1'b0, hdr_len};
    assign over     = (hdr_len > i_max) || (len_sum > {1'b0, i_max});

    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_shift = r_hdr_shift;
        n_frag_rem  = r_frag_rem;
        n_in_body   = r_in_body;
        n_last_frag = r_last_frag;
        n_msg_len   = r_msg_len;
        n_err       = r_err;
        o_push      = 1'b0;
        o_res       = '0;
        if (accept && !r_err) begin
            if (!r_in_body) begin
                if (r_hdr_cnt != HDR_LAST) begin
                    n_hdr_shift = {r_hdr_shift[HDR_SHIFT_W-BYTE_W-1:0], i_data};
                    n_hdr_cnt   = r_hdr_cnt + 1'b1;
                end else begin
                    n_hdr_cnt   = '0;
                    n_hdr_shift = '0;
                    if (over) begin
                        n_err             = 1'b1;
                        o_push            = 1'b1;
                        o_res.frame_error = 1'b1;
                    end else if (hdr_len == '0) begin
                        // An empty last fragment closes the message with a bare marker.
                        if (hdr_last) begin
                            n_msg_len     = '0;
                            o_push        = 1'b1;
                            o_res.msg_end = 1'b1;
                        end
                    end else begin
                        n_in_body   = 1'b1;
                        n_frag_rem  = hdr_len;
                        n_last_frag = hdr_last;
                    end
                end
            end else begin
                n_frag_rem       = r_frag_rem - 1'b1;
                n_msg_len        = r_msg_len + 1'b1;
                o_push           = 1'b1;
                o_res.data       = i_data;
                o_res.byte_valid = 1'b1;
                if (r_frag_rem == LEN_W'(1)) begin
                    n_in_body = 1'b0;
                    if (r_last_frag) begin
                        n_last_frag   = 1'b0;
                        n_msg_len     = '0;
                        o_res.msg_end = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= '0;
            r_hdr_shift <= '0;
            r_frag_rem  <= '0;
            r_in_body   <= 1'b0;
            r_last_frag <= 1'b0;
            r_msg_len   <= '0;
            r_err       <= 1'b0;
        end else begin
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_shift <= n_hdr_shift;
            r_frag_rem  <= n_frag_rem;
            r_in_body   <= n_in_body;
            r_last_frag <= n_last_frag;
            r_msg_len   <= n_msg_len;
            r_err       <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_push)
        else $error("result pushed after a frame error");
    a_body_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_hdr_cnt == '0) && (r_frag_rem != '0))
        else $error("body state with pending header or empty fragment");
    a_error_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.frame_error) |=> r_err)
        else $error("frame error not latched");
`endif

endmodule

// ----- hdl/rmd_fifo.sv -----
// ----------------------------------------------------------------------------
// rmd_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module rmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rmd_pkg::t_result i_res,
    input  logic             i_pop,
    output rmd_pkg::t_result o_res,
    output rmd_pkg::t_q_stat o_stat
);
    import rmd_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_res        = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? Q_PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = do_pop  ? Q_PTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ----- hdl/rmd_back.sv -----
// ----------------------------------------------------------------------------
// rmd_back
// Output register stage: drains the queue onto the master stream.
// ----------------------------------------------------------------------------
module rmd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmd_pkg::t_q_stat           i_q_stat,
    input  rmd_pkg::t_result           i_res,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [rmd_pkg::BYTE_W-1:0] o_m_tdata,
    output logic                       o_m_tlast,
    output logic [1:0]                 o_m_tuser
);
    import rmd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // The register reloads whenever it is empty or its item is being taken.
    assign o_pop   = !i_q_stat.empty && (!r_valid || i_m_tready);
    assign n_valid = o_pop || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_res.data;
    assign o_m_tlast  = r_res.msg_end;
    assign o_m_tuser  = {r_res.frame_error, r_res.byte_valid};

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("pop from an empty queue");
`endif

endmodule

// ----- hdl/rpc_record_mark_deframer_top.sv -----
// ----------------------------------------------------------------------------
// rpc_record_mark_deframer_top
// Record marking deframer for RPC messages carried over a byte stream.
//
// The slave stream takes one received byte per item in tdata. Each fragment
// begins with a four-byte big-endian header; bit 31 flags the last fragment
// and bits 30..0 give its body length. Body bytes leave on the master stream
// one per item, with tlast on the final byte of a message. An empty last
// fragment yields a bare item with tlast set and no data. A fragment that
// pushes the message past max_message_bytes yields one error item, after
// which all input is consumed and dropped until reset.
// The block takes one byte every clock cycle while the result queue has room.
// A result enters the result queue when its byte is taken and then moves
// into the output register that drives the master side. Header bytes give
// no result, but for a closing empty header or an error header.
// When the receiver stalls, the four-entry queue fills and then tready drops
// on the slave side; it rises again as soon as one entry drains.
// Reset clears the parser, empties the queue and loads the limit register
// with 8 MiB. The limit is written through the APB port; paddr is not decoded.
// ----------------------------------------------------------------------------
module rpc_record_mark_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] body_byte
    output logic        o_m_tlast,   // message_end
    output logic [1:0]  o_m_tuser,   // [0] byte_valid, [1] frame_error
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [1:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import rmd_pkg::*;

    logic [LEN_W-1:0] r_max;
    logic             cfg_wr;
    logic             push, pop;
    t_result          front_res, q_res;
    t_q_stat          q_stat;

    // Only one word exists, so every byte address inside it selects the limit.
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata = {1'b0, r_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
        end else if (cfg_wr) begin
            r_max <= i_pwdata[LEN_W-1:0];
        end
    end

    rmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_data   (i_s_tdata),
        .i_max    (r_max),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_res    (front_res)
    );

    rmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (front_res),
        .i_pop   (pop),
        .o_res   (q_res),
        .o_stat  (q_stat)
    );

    rmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_res      (q_res),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
